[rtl/srgbtc_pkg.sv]
// Package for the sRGB transfer converter: curve constants, table fill sequencer states,
// and the elaboration-time functions that seed the exact integer curve sweeps.
// Depends on nothing; imported by srgb_transfer_convert.
package srgbtc_pkg;

    // Sample width limits.
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SAMPLE_BITS_MAX = 24;

    // Mode codes carried on the input item.
    localparam logic MODE_DECODE = 1'b0;
    localparam logic MODE_ENCODE = 1'b1;

    // The power segments are compared as exact integers raised to the 5th and 12th powers.
    // After common factors cancel, decode tests
    //   32 * (200x + 11m)^12 >= (2c - 1)^5 * 211^12 * m^7
    // and encode tests
    //   x^5 * 211^12 * m^7 >= (200c - 100 + 11m)^12.
    localparam int POLY_DEG      = 12;
    localparam int ROOT_EXP      = 5;
    localparam int CURVE_STEP    = 200;
    localparam int CURVE_OFFSET  = 11;
    localparam int CURVE_GAIN    = 211;
    localparam int CURVE_HALF    = 100;
    localparam int DEC_PREFACTOR = 32;

    // Widest value of either side of the compare at the largest sample width.
    localparam int WIDE_BITS = POLY_DEG * SAMPLE_BITS_MAX + 101;
    typedef logic [WIDE_BITS-1:0] wide_t;

    // Linear segment thresholds: x <= NUM * m / DEN takes the linear segment.
    localparam longint unsigned LIN_DEC_NUM = 4045;
    localparam longint unsigned LIN_DEC_DEN = 100000;
    localparam longint unsigned LIN_ENC_NUM = 31308;
    localparam longint unsigned LIN_ENC_DEN = 10000000;

    // Linear segment as a running quotient and remainder.
    // Decode: (50x + 323) / 646.  Encode: (2584x + 100) / 200 = 12x + (184x + 100) / 200.
    localparam int LIN_REM_BITS     = 10;
    localparam int LIN_DEC_REM_INIT = 323;
    localparam int LIN_DEC_REM_STEP = 50;
    localparam int LIN_DEC_DIV      = 646;
    localparam int LIN_DEC_Q_STEP   = 0;
    localparam int LIN_ENC_REM_INIT = 100;
    localparam int LIN_ENC_REM_STEP = 184;
    localparam int LIN_ENC_DIV      = 200;
    localparam int LIN_ENC_Q_STEP   = 12;

    // Result queue behind the table read.
    localparam int QDEPTH     = 4;
    localparam int Q_PTR_BITS = 2;
    localparam int Q_CNT_BITS = 3;

    // Table fill sequencer.
    typedef enum logic [1:0] {
        FILL_LOAD,
        FILL_SWEEP,
        SERVE
    } fill_state_t;

    // Integer power, used only at elaboration.
    function automatic wide_t wide_pow(input wide_t b, input int unsigned e);
        wide_t acc;
        acc = wide_t'(1);
        for (int unsigned i = 0; i < e; i++) begin
            acc = acc * b;
        end
        return acc;
    endfunction

    // One side of the compare evaluated at step t. The code side is taken at code t + 1.
    function automatic wide_t poly_value(input logic encode, input logic code_side,
                                         input int unsigned t, input int unsigned code_max);
        wide_t tw;
        wide_t mw;
        wide_t k_fac;
        wide_t val;
        tw    = wide_t'(t);
        mw    = wide_t'(code_max);
        k_fac = wide_pow(wide_t'(CURVE_GAIN), POLY_DEG) * wide_pow(mw, POLY_DEG - ROOT_EXP);
        if (encode == MODE_DECODE) begin
            if (!code_side) begin
                val = wide_t'(DEC_PREFACTOR) *
                      wide_pow(wide_t'(CURVE_STEP) * tw + wide_t'(CURVE_OFFSET) * mw, POLY_DEG);
            end else begin
                val = wide_pow(wide_t'(2) * tw + wide_t'(1), ROOT_EXP) * k_fac;
            end
        end else begin
            if (!code_side) begin
                val = wide_pow(tw, ROOT_EXP) * k_fac;
            end else begin
                val = wide_pow(wide_t'(CURVE_STEP) * tw + wide_t'(CURVE_HALF) +
                               wide_t'(CURVE_OFFSET) * mw, POLY_DEG);
            end
        end
        return val;
    endfunction

    // k-th forward difference at step 0, the starting content of one difference register.
    function automatic wide_t diff_init(input logic encode, input logic code_side,
                                        input int unsigned k, input int unsigned code_max);
        wide_t v [POLY_DEG+1];
        for (int unsigned i = 0; i <= POLY_DEG; i++) begin
            v[i] = poly_value(encode, code_side, i, code_max);
        end
        for (int unsigned lvl = 1; lvl <= k; lvl++) begin
            for (int unsigned i = 0; i + lvl <= POLY_DEG; i++) begin
                v[i] = v[i+1] - v[i];
            end
        end
        return v[0];
    endfunction

endpackage

[rtl/srgb_transfer_convert.sv]
// sRGB transfer converter top level: a lookup table memory holding both curves, the sweep
// that fills it exactly after reset, and the read path with its result queue.
// Depends on srgbtc_pkg.

// After reset the block fills its table of 2^(SAMPLE_BITS+1) codes (decode curve, then
// encode curve) with exact results and holds s_ready low meanwhile. From then on it takes
// one item per clock, each item being a single read of the table; the result is
// registered from the table and then written into a four-entry queue, which keeps accepting
// while results wait on m_ready, so the input side stalls only once that queue and the read
// in flight together hold four items.
module srgb_transfer_convert #(
    parameter int SAMPLE_BITS = srgbtc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_mode,
    input  logic [SAMPLE_BITS-1:0] s_sample_in,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SAMPLE_BITS-1:0] m_sample_out
);
    import srgbtc_pkg::*;

    localparam int          W         = POLY_DEG * SAMPLE_BITS + 101;
    localparam int unsigned M_INT     = (1 << SAMPLE_BITS) - 1;
    localparam int          ADDR_BITS = SAMPLE_BITS + 1;
    localparam int          MEM_DEPTH = 1 << ADDR_BITS;

    localparam logic [SAMPLE_BITS-1:0] CODE_MAX = {SAMPLE_BITS{1'b1}};
    localparam logic [SAMPLE_BITS-1:0] XTH_DEC  =
        SAMPLE_BITS'(LIN_DEC_NUM * longint'(M_INT) / LIN_DEC_DEN);
    localparam logic [SAMPLE_BITS-1:0] XTH_ENC  =
        SAMPLE_BITS'(LIN_ENC_NUM * longint'(M_INT) / LIN_ENC_DEN);

    // Sequencer state.
    fill_state_t state_reg;
    fill_state_t state_next;
    logic        mode_reg;
    logic        load_en;
    logic        sweep_en;
    logic        serving;

    // Sweep registers: difference stacks for the sample side and the code side.
    logic [W-1:0]             xd_reg  [POLY_DEG+1];
    logic [W-1:0]             cd_reg  [POLY_DEG+1];
    logic [W-1:0]             xd_init [POLY_DEG+1];
    logic [W-1:0]             cd_init [POLY_DEG+1];
    logic [SAMPLE_BITS-1:0]   x_reg;
    logic [SAMPLE_BITS-1:0]   c_reg;
    logic [SAMPLE_BITS-1:0]   lin_q_reg;
    logic [SAMPLE_BITS-1:0]   lin_q_next;
    logic [LIN_REM_BITS-1:0]  lin_rem_reg;
    logic [LIN_REM_BITS-1:0]  lin_rem_next;
    logic [LIN_REM_BITS:0]    lin_sum;
    logic [LIN_REM_BITS-1:0]  lin_div;
    logic [LIN_REM_BITS-1:0]  lin_rem_step;
    logic [LIN_REM_BITS-1:0]  lin_rem_init;
    logic [SAMPLE_BITS-1:0]   lin_q_step;
    logic [SAMPLE_BITS-1:0]   x_thresh;
    logic                     c_adv;
    logic                     sweep_done;

    // Table memory ports.
    logic [SAMPLE_BITS-1:0] lut_mem [MEM_DEPTH];
    logic                   wr_en;
    logic [ADDR_BITS-1:0]   wr_addr;
    logic [SAMPLE_BITS-1:0] wr_data;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    // Read path and result queue.
    logic                   in_accept;
    logic                   p1_valid_reg;
    logic [SAMPLE_BITS-1:0] q_data_reg [QDEPTH];
    logic [Q_PTR_BITS-1:0]  q_wr_ptr_reg;
    logic [Q_PTR_BITS-1:0]  q_rd_ptr_reg;
    logic [Q_CNT_BITS-1:0]  q_count_reg;
    logic [Q_CNT_BITS-1:0]  q_count_next;
    logic [Q_CNT_BITS-1:0]  occupancy;
    logic                   q_push;
    logic                   q_pop;

    // Starting differences for both curves, worked out at elaboration.
    for (genvar k = 0; k <= POLY_DEG; k++) begin : g_init
        localparam wide_t XD_DEC = diff_init(MODE_DECODE, 1'b0, k, M_INT);
        localparam wide_t CD_DEC = diff_init(MODE_DECODE, 1'b1, k, M_INT);
        localparam wide_t XD_ENC = diff_init(MODE_ENCODE, 1'b0, k, M_INT);
        localparam wide_t CD_ENC = diff_init(MODE_ENCODE, 1'b1, k, M_INT);
        assign xd_init[k] = (mode_reg == MODE_ENCODE) ? XD_ENC[W-1:0] : XD_DEC[W-1:0];
        assign cd_init[k] = (mode_reg == MODE_ENCODE) ? CD_ENC[W-1:0] : CD_DEC[W-1:0];
    end

    // Per-curve constants of the linear segment.
    always_comb begin
        if (mode_reg == MODE_ENCODE) begin
            lin_div      = LIN_REM_BITS'(LIN_ENC_DIV);
            lin_rem_step = LIN_REM_BITS'(LIN_ENC_REM_STEP);
            lin_rem_init = LIN_REM_BITS'(LIN_ENC_REM_INIT);
            lin_q_step   = SAMPLE_BITS'(LIN_ENC_Q_STEP);
            x_thresh     = XTH_ENC;
        end else begin
            lin_div      = LIN_REM_BITS'(LIN_DEC_DIV);
            lin_rem_step = LIN_REM_BITS'(LIN_DEC_REM_STEP);
            lin_rem_init = LIN_REM_BITS'(LIN_DEC_REM_INIT);
            lin_q_step   = SAMPLE_BITS'(LIN_DEC_Q_STEP);
            x_thresh     = XTH_DEC;
        end
    end

    // The code advances while the curve at x still reaches the next rounding threshold.
    assign c_adv      = (c_reg != CODE_MAX) && (xd_reg[0] >= cd_reg[0]);
    assign sweep_done = sweep_en && !c_adv && (x_reg == CODE_MAX);

    // Next linear quotient and remainder for the following sample.
    always_comb begin
        lin_sum = {1'b0, lin_rem_reg} + {1'b0, lin_rem_step};
        if (lin_sum >= {1'b0, lin_div}) begin
            lin_rem_next = LIN_REM_BITS'(lin_sum - {1'b0, lin_div});
            lin_q_next   = lin_q_reg + lin_q_step + SAMPLE_BITS'(1);
        end else begin
            lin_rem_next = LIN_REM_BITS'(lin_sum);
            lin_q_next   = lin_q_reg + lin_q_step;
        end
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FILL_LOAD:  state_next = FILL_SWEEP;
            FILL_SWEEP: begin
                if (sweep_done) begin
                    state_next = (mode_reg == MODE_ENCODE) ? SERVE : FILL_LOAD;
                end
            end
            SERVE:      state_next = SERVE;
            default:    state_next = FILL_LOAD;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        load_en  = 1'b0;
        sweep_en = 1'b0;
        serving  = 1'b0;
        case (state_reg)
            FILL_LOAD:  load_en  = 1'b1;
            FILL_SWEEP: sweep_en = 1'b1;
            SERVE:      serving  = 1'b1;
            default:    load_en  = 1'b0;
        endcase
    end

    // Sequencer and fill curve registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FILL_LOAD;
            mode_reg  <= MODE_DECODE;
        end else begin
            state_reg <= state_next;
            if (sweep_done) begin
                mode_reg <= MODE_ENCODE;
            end
        end
    end

    // Sweep: after loading the starting values, either step the code side or write one entry and step the sample side.
    always_ff @(posedge aclk) begin
        if (load_en) begin
            x_reg       <= '0;
            c_reg       <= '0;
            lin_q_reg   <= '0;
            lin_rem_reg <= lin_rem_init;
            for (int k = 0; k <= POLY_DEG; k++) begin
                xd_reg[k] <= xd_init[k];
                cd_reg[k] <= cd_init[k];
            end
        end else if (sweep_en) begin
            if (c_adv) begin
                c_reg <= c_reg + SAMPLE_BITS'(1);
                for (int k = 0; k < POLY_DEG; k++) begin
                    cd_reg[k] <= cd_reg[k] + cd_reg[k+1];
                end
            end else begin
                x_reg       <= x_reg + SAMPLE_BITS'(1);
                lin_q_reg   <= lin_q_next;
                lin_rem_reg <= lin_rem_next;
                for (int k = 0; k < POLY_DEG; k++) begin
                    xd_reg[k] <= xd_reg[k] + xd_reg[k+1];
                end
            end
        end
    end

    // Table write during the fill, table read for each accepted item.
    assign wr_en   = sweep_en && !c_adv;
    assign wr_addr = {mode_reg, x_reg};
    assign wr_data = (x_reg <= x_thresh) ? lin_q_reg : c_reg;
    assign rd_addr = {s_mode, s_sample_in};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            lut_mem[wr_addr] <= wr_data;
        end
        if (in_accept) begin
            rd_data_reg <= lut_mem[rd_addr];
        end
    end

    // Accept while the queue has room for everything already in flight.
    assign occupancy = q_count_reg + Q_CNT_BITS'(p1_valid_reg);
    assign s_ready   = serving && (occupancy < Q_CNT_BITS'(QDEPTH));
    assign in_accept = s_valid && s_ready;

    assign q_push       = p1_valid_reg;
    assign q_pop        = m_valid && m_ready;
    assign q_count_next = q_count_reg + Q_CNT_BITS'(q_push) - Q_CNT_BITS'(q_pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_count_reg  <= '0;
        end else begin
            p1_valid_reg <= in_accept;
            q_count_reg  <= q_count_next;
            if (q_push) begin
                q_wr_ptr_reg <= q_wr_ptr_reg + Q_PTR_BITS'(1);
            end
            if (q_pop) begin
                q_rd_ptr_reg <= q_rd_ptr_reg + Q_PTR_BITS'(1);
            end
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (q_push) begin
            q_data_reg[q_wr_ptr_reg] <= rd_data_reg;
        end
    end

    assign m_valid      = (q_count_reg != '0);
    assign m_sample_out = q_data_reg[q_rd_ptr_reg];

    // Items in flight never exceed the queue depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= Q_CNT_BITS'(QDEPTH))
        else $error("result queue overrun");

    // A table read is only ever issued once the fill has finished.
    assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg |-> state_reg == SERVE)
        else $error("table read before fill completion");

    // Serving starts only after the last encode entry was written.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SERVE && $past(state_reg) == FILL_SWEEP)
            |-> ($past(mode_reg) == MODE_ENCODE && $past(x_reg) == CODE_MAX))
        else $error("fill ended early");

    // The linear remainder stays below its divisor throughout the sweep.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sweep_en |-> lin_rem_reg < lin_div)
        else $error("linear segment remainder out of range");

endmodule

[verif/tb_srgb_transfer_convert.sv]
`timescale 1ns / 1ps
// Self-checking testbench for srgb_transfer_convert: drives random and corner samples in both
// directions and checks every result against an exact integer model of the sRGB curve.
// Depends on srgbtc_pkg and srgb_transfer_convert.

localparam int SAMPLE_W = 16;
localparam longint unsigned CODE_TOP = 65535;

// Wide enough for both sides of the 12th/5th power comparison at 16 bits.
typedef logic [447:0] wide_num_t;
typedef logic [SAMPLE_W-1:0] code_t;

typedef struct packed {
    logic  mode;
    code_t sample;
    code_t code;
} conversion_t;

// Scoreboard: predicts each converted code and matches results in order.
class srgb_scoreboard;
    conversion_t expected_q[$];
    int unsigned fault_count;
    int unsigned shown_count;

    // Constant factors of the power segment comparisons.
    wide_num_t dec_sample_gain;
    wide_num_t dec_code_gain;
    wide_num_t enc_sample_gain;
    wide_num_t enc_code_gain;

    function new();
        wide_num_t m;
        m = wide_num_t'(CODE_TOP);
        fault_count = 0;
        shown_count = 0;
        dec_sample_gain = raise(wide_num_t'(2) * m, 5);
        dec_code_gain   = raise(wide_num_t'(1055) * m, 12);
        enc_sample_gain = raise(wide_num_t'(2110) * m, 12);
        enc_code_gain   = raise(m, 5);
    endfunction

    function wide_num_t raise(wide_num_t base, int unsigned e);
        wide_num_t acc;
        acc = wide_num_t'(1);
        for (int unsigned i = 0; i < e; i++) begin
            acc = acc * base;
        end
        return acc;
    endfunction

    // Largest code c whose lower rounding edge (c - 1/2) lies at or under the exact curve.
    function code_t power_code(logic mode, code_t sample);
        wide_num_t m;
        wide_num_t xw;
        wide_num_t lhs;
        wide_num_t rhs;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        m  = wide_num_t'(CODE_TOP);
        xw = wide_num_t'(sample);
        if (mode == srgbtc_pkg::MODE_DECODE) begin
            lhs = raise(wide_num_t'(1000) * xw + wide_num_t'(55) * m, 12) * dec_sample_gain;
        end else begin
            lhs = raise(xw, 5) * enc_sample_gain;
        end
        lo = 0;
        hi = 32'(CODE_TOP);
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (mode == srgbtc_pkg::MODE_DECODE) begin
                rhs = raise(wide_num_t'(2 * mid - 1), 5) * dec_code_gain;
            end else begin
                rhs = enc_code_gain *
                      raise(wide_num_t'(1000 * (2 * mid - 1)) + wide_num_t'(110) * m, 12);
            end
            if (lhs >= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return code_t'(lo);
    endfunction

    // A sample exactly on a threshold takes the linear segment.
    function code_t convert(logic mode, code_t sample);
        longint unsigned x;
        x = 64'(sample);
        if (mode == srgbtc_pkg::MODE_DECODE) begin
            if (100000 * x <= 4045 * CODE_TOP) begin
                return code_t'((50 * x + 323) / 646);
            end
            return power_code(mode, sample);
        end
        if (10000000 * x <= 31308 * CODE_TOP) begin
            return code_t'((2584 * x + 100) / 200);
        end
        return power_code(mode, sample);
    endfunction

    function void note_input(logic mode, code_t sample);
        conversion_t item;
        item.mode   = mode;
        item.sample = sample;
        item.code   = convert(mode, sample);
        expected_q.push_back(item);
    endfunction

    function void check_result(code_t actual);
        conversion_t item;
        if (expected_q.size() == 0) begin
            fault_count++;
            if (shown_count < 10) begin
                shown_count++;
                $display("ERROR: result %0d arrived with no item outstanding", actual);
            end
            return;
        end
        item = expected_q.pop_front();
        if (actual !== item.code) begin
            fault_count++;
            if (shown_count < 10) begin
                shown_count++;
                $display("ERROR: mode %0d sample_in %0d expected %0d got %0d",
                         item.mode, item.sample, item.code, actual);
            end
        end
    endfunction

    function int unsigned outstanding();
        return expected_q.size();
    endfunction

    // Results that never came count as failures.
    function void flag_leftover();
        if (expected_q.size() != 0) begin
            fault_count += expected_q.size();
            $display("ERROR: %0d results never arrived", expected_q.size());
        end
    endfunction
endclass

module tb_srgb_transfer_convert;

    // The stall limit lies well above the table fill after reset, during which s_ready stays low.
    localparam int unsigned STALL_LIMIT = 1048576;
    localparam int unsigned RANDOM_PER_PHASE = 634;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    logic  s_mode;
    code_t s_sample_in;
    logic  m_valid;
    logic  m_ready;
    code_t m_sample_out;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    code_t corner_codes[$];

    srgb_scoreboard sb;

    srgb_transfer_convert #(
        .SAMPLE_BITS(SAMPLE_W)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_mode(s_mode),
        .s_sample_in(s_sample_in),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_sample_out(m_sample_out)
    );

    initial begin
        aclk = 1'b0;
    end

    always #6 aclk = ~aclk;

    // Drive one item, starting and ending at a falling edge.
    task automatic send_item(input logic mode, input code_t sample);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid     = 1'b0;
            s_mode      = 1'($urandom_range(1));
            s_sample_in = code_t'($urandom_range(65535));
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_mode      = mode;
        s_sample_in = sample;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    // Random samples weighted toward the segment thresholds and both ends of the range.
    function automatic code_t pick_sample(logic mode);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40) begin
            return code_t'($urandom_range(65535));
        end
        if (r < 60) begin
            if (mode == srgbtc_pkg::MODE_DECODE) begin
                return code_t'($urandom_range(2700, 2600));
            end
            return code_t'($urandom_range(260, 150));
        end
        if (r < 80) begin
            return code_t'($urandom_range(4095));
        end
        return code_t'($urandom_range(65535, 61440));
    endfunction

    // Receiver back-pressure changes at the falling edge.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Observe both channels at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_input(s_mode, s_sample_in);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_sample_out);
            end
        end
    end

    // End the run if neither channel moves an item for too long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic m;
        sb = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_mode        = 1'b0;
        s_sample_in   = '0;
        send_idle_pct = 25;
        recv_idle_pct = 83;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Range ends, threshold neighbors, and alternating bit patterns in both directions.
        corner_codes = '{16'd0, 16'd1, 16'd205, 16'd206, 16'd2650, 16'd2651,
                         16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'd65534, 16'd65535};
        foreach (corner_codes[i]) begin
            send_item(srgbtc_pkg::MODE_DECODE, corner_codes[i]);
            send_item(srgbtc_pkg::MODE_ENCODE, corner_codes[i]);
        end

        // Three idling regimes: slow receiver, slow sender, then full rate.
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 83;
                recv_idle_pct = 25;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int unsigned k = 0; k < RANDOM_PER_PHASE; k++) begin
                m = 1'($urandom_range(1));
                send_item(m, pick_sample(m));
            end
        end
        s_valid = 1'b0;

        while (sb.outstanding() != 0) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);
        sb.flag_leftover();
        if (sb.fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
rtl/srgbtc_pkg.sv
rtl/srgb_transfer_convert.sv
verif/tb_srgb_transfer_convert.sv
